// ===== hdl/circ_pkg.sv =====
`timescale 1ns / 1ps
package circ_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam int unsigned CENTRE_W = 12;
  localparam int unsigned STEP_W   = 10;
  localparam int unsigned DEC_W    = 16;
  localparam int unsigned POS_W    = 14;
  localparam int unsigned OFFS_W   = 15;

  typedef struct packed {
    logic signed [CENTRE_W-1:0] cx;
    logic signed [CENTRE_W-1:0] cy;
    logic signed [STEP_W-1:0]   x;
    logic signed [STEP_W-1:0]   y;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic signed [POS_W-1:0] col;
    logic signed [POS_W-1:0] row;
    logic [2:0]              octant;
    logic                    last;
  } point_t;

endpackage

// ===== hdl/circ_front.sv =====
`timescale 1ns / 1ps
module circ_front import circ_pkg::*; #(
  parameter int MAX_RADIUS = 511
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic signed [CENTRE_W-1:0] center_x_i,
  input  logic signed [CENTRE_W-1:0] center_y_i,
  input  logic [8:0]                 radius_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output job_t                       push_job_o
);

  logic signed [CENTRE_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [STEP_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [DEC_W-1:0]    d_q, d_d;
  logic                       busy_q, busy_d;

  logic                       acc;
  logic [8:0]                 r_sat;
  logic signed [STEP_W-1:0]   x_inc, y_dec, y_nx;
  logic signed [DEC_W-1:0]    xe, ye, d_nx;
  logic                       done;

  assign in_ready_o = push_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    r_sat = ({2'b00, radius_i} > 11'(MAX_RADIUS)) ? 9'(MAX_RADIUS) : radius_i;
    x_inc = x_q + 10'sd1;
    y_dec = y_q - 10'sd1;
    xe    = DEC_W'(x_inc);
    if (d_q > 16'sd0) begin
      y_nx = y_dec;
      ye   = DEC_W'(y_dec);
      d_nx = d_q + ((xe - ye) <<< 2) + 16'sd10;
    end else begin
      y_nx = y_q;
      ye   = DEC_W'(y_q);
      d_nx = d_q + (xe <<< 2) + 16'sd6;
    end
    done = y_nx < x_inc;
  end

  always_comb begin
    cx_d         = cx_q;
    cy_d         = cy_q;
    x_d          = x_q;
    y_d          = y_q;
    d_d          = d_q;
    busy_d       = busy_q;
    push_valid_o = 1'b0;
    push_job_o   = '{cx: cx_q, cy: cy_q, x: x_inc, y: y_nx, last: done};
    if (acc) begin
      if (func_i == FUNC_START) begin
        cx_d         = center_x_i;
        cy_d         = center_y_i;
        x_d          = '0;
        y_d          = STEP_W'(r_sat);
        d_d          = 16'sd3 - DEC_W'({r_sat, 1'b0});
        busy_d       = 1'b1;
        push_valid_o = 1'b1;
        push_job_o   = '{cx: center_x_i, cy: center_y_i, x: '0,
                         y: STEP_W'(r_sat), last: 1'b0};
      end else if (busy_q) begin
        x_d          = x_inc;
        y_d          = y_nx;
        d_d          = d_nx;
        busy_d       = !done;
        push_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      d_q    <= '0;
      busy_q <= 1'b0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      x_q    <= x_d;
      y_q    <= y_d;
      d_q    <= d_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== hdl/circ_queue.sv =====
`timescale 1ns / 1ps
module circ_queue import circ_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign push_ready_o = cnt_q != (QPTR_W+1)'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_job_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/circ_back.sv =====
`timescale 1ns / 1ps
module circ_back import circ_pkg::*; #(
  parameter int SCREEN_COLS = 640,
  parameter int SCREEN_ROWS = 400,
  parameter int ROW_BYTES   = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OFFS_W-1:0] byte_offset_o,
  output logic [7:0]        bit_mask_o,
  output logic              visible_o,
  output logic [2:0]        octant_o,
  output logic              last_o
);

  localparam int unsigned RB_W = $clog2(ROW_BYTES + 1);
  localparam logic signed [POS_W-1:0] ColLim = POS_W'(SCREEN_COLS);
  localparam logic signed [POS_W-1:0] RowLim = POS_W'(SCREEN_ROWS);
  localparam logic [RB_W-1:0] RowBytes = RB_W'(ROW_BYTES);

  logic [2:0]              oct_q, oct_d;
  logic                    a_valid_q, a_valid_d;
  point_t                  a_q, a_d;
  logic                    a_ready, a_load, b_adv;

  logic signed [POS_W-1:0] sa, sb, col, row;

  logic                    vis;
  logic [11+RB_W-1:0]      prod;
  logic [OFFS_W-1:0]       offs;

  logic                    out_valid_q, out_valid_d;
  logic [OFFS_W-1:0]       offs_q, offs_d;
  logic [7:0]              mask_q, mask_d;
  logic                    vis_q, vis_d;
  logic [2:0]              octo_q, octo_d;
  logic                    last_q, last_d;

  assign b_adv       = !out_valid_q || out_ready_i;
  assign a_ready     = !a_valid_q || b_adv;
  assign a_load      = job_valid_i && a_ready;
  assign job_ready_o = a_ready && (oct_q == 3'd7);

  // octant bit 2 swaps x and y, bit 0 mirrors the column, bit 1 the row
  always_comb begin
    sa  = oct_q[2] ? POS_W'(job_i.y) : POS_W'(job_i.x);
    sb  = oct_q[2] ? POS_W'(job_i.x) : POS_W'(job_i.y);
    col = POS_W'(job_i.cx) + (oct_q[0] ? -sa : sa);
    row = POS_W'(job_i.cy) + (oct_q[1] ? -sb : sb);
    oct_d     = a_load ? oct_q + 3'd1 : oct_q;
    a_valid_d = a_load ? 1'b1 : (b_adv ? 1'b0 : a_valid_q);
    a_d       = a_load ? '{col: col, row: row, octant: oct_q,
                           last: job_i.last && (oct_q == 3'd7)} : a_q;
  end

  always_comb begin
    vis  = (a_q.col >= 0) && (a_q.col < ColLim) && (a_q.row >= 0) && (a_q.row < RowLim);
    prod = a_q.row[10:0] * RowBytes;
    offs = OFFS_W'(prod) + OFFS_W'(a_q.col[10:3]);
    out_valid_d = b_adv ? a_valid_q : out_valid_q;
    offs_d      = offs_q;
    mask_d      = mask_q;
    vis_d       = vis_q;
    octo_d      = octo_q;
    last_d      = last_q;
    if (b_adv && a_valid_q) begin
      offs_d = vis ? offs : '0;
      mask_d = vis ? (8'h80 >> a_q.col[2:0]) : 8'h00;
      vis_d  = vis;
      octo_d = a_q.octant;
      last_d = a_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    offs_q <= offs_d;
    mask_q <= mask_d;
    vis_q  <= vis_d;
    octo_q <= octo_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q       <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      oct_q       <= oct_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_offset_o = offs_q;
  assign bit_mask_o    = mask_q;
  assign visible_o     = vis_q;
  assign octant_o      = octo_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/circle_rasterizer_octant.sv =====
`timescale 1ns / 1ps
// an accepted input word passes the job queue, then the back end's point register and
//   its output register; a start, or a step while a circle is busy, gives eight result
//   words, one per cycle unless stalled, and its job leaves the queue at octant seven
// a two-entry job queue lets the front take words while results wait
// reset clears circle state, queue, octant counter and output valid
module circle_rasterizer_octant import circ_pkg::*; #(
  parameter int SCREEN_COLS = 640,
  parameter int SCREEN_ROWS = 400,
  parameter int ROW_BYTES   = 80,
  parameter int MAX_RADIUS  = 511
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic signed [CENTRE_W-1:0] center_x_i,
  input  logic signed [CENTRE_W-1:0] center_y_i,
  input  logic [8:0]                 radius_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [OFFS_W-1:0]          byte_offset_o,
  output logic [7:0]                 bit_mask_o,
  output logic                       visible_o,
  output logic [2:0]                 octant_o,
  output logic                       last_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  circ_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .center_x_i, .center_y_i, .radius_i,
    .push_valid_o(push_valid), .push_ready_i(push_ready), .push_job_o(push_job)
  );

  circ_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_job_i(push_job),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_job_o(pop_job)
  );

  circ_back #(
    .SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS), .ROW_BYTES(ROW_BYTES)
  ) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(pop_valid), .job_ready_o(pop_ready), .job_i(pop_job),
    .out_valid_o, .out_ready_i, .byte_offset_o, .bit_mask_o,
    .visible_o, .octant_o, .last_o
  );

endmodule

// ===== hdl/circ_checker.sv =====
`timescale 1ns / 1ps
module circ_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [14:0] byte_offset_o,
  input logic [7:0]  bit_mask_o,
  input logic        visible_o,
  input logic [2:0]  octant_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_offset_o)
      && $stable(bit_mask_o) && $stable(octant_o) && $stable(last_o))
    else $error("result word changed while stalled");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> byte_offset_o == 15'd0 && bit_mask_o == 8'd0)
    else $error("clipped point has nonzero offset or mask");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |-> $onehot(bit_mask_o))
    else $error("visible point mask not one-hot");

  a_last_oct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> octant_o == 3'd7)
    else $error("last flag outside final octant");

endmodule

bind circle_rasterizer_octant circ_checker u_circ_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .byte_offset_o,
  .bit_mask_o, .visible_o, .octant_o, .last_o
);
